@@ hdl/gmig_pkg.sv @@
// Shared widths, region codes and types for the grid mesh index generator.
`timescale 1ns / 1ps

package gmig_pkg;

    // Default number of squares along one side of the grid
    localparam int CELL_SIZE_DEF = 64;

    // Width of one vertex index and of the running triangle count
    localparam int IDX_W = 13;
    localparam int TRI_W = 14;

    // Vertices per square (two triangles) and triangles per drawn square
    localparam int SQUARE_VERTS    = 6;
    localparam int TRIS_PER_SQUARE = 2;

    // Walk regions
    localparam int REGION_W = 3;
    localparam logic [REGION_W-1:0] REGION_GRID   = 3'd0;
    localparam logic [REGION_W-1:0] REGION_TOP    = 3'd1;
    localparam logic [REGION_W-1:0] REGION_BOTTOM = 3'd2;
    localparam logic [REGION_W-1:0] REGION_LEFT   = 3'd3;
    localparam logic [REGION_W-1:0] REGION_RIGHT  = 3'd4;

    typedef logic [IDX_W-1:0]    idx_t;
    typedef logic [TRI_W-1:0]    tri_count_t;
    typedef logic [REGION_W-1:0] region_t;

endpackage

@@ hdl/gmig_if.sv @@
// Valid/ready channel interfaces for the square flags and the index results.
`timescale 1ns / 1ps

interface gmig_in_if;
    logic valid;
    logic ready;
    logic square_empty;

    modport source (output valid, output square_empty, input ready);
    modport sink (input valid, input square_empty, output ready);
endinterface

interface gmig_out_if;
    import gmig_pkg::*;

    logic       valid;
    logic       ready;
    logic       drawn;
    idx_t       idx0;
    idx_t       idx1;
    idx_t       idx2;
    idx_t       idx3;
    idx_t       idx4;
    idx_t       idx5;
    tri_count_t triangles_so_far;
    logic       walk_done;

    modport source (
        output valid, output drawn,
        output idx0, output idx1, output idx2, output idx3, output idx4, output idx5,
        output triangles_so_far, output walk_done,
        input  ready
    );
    modport sink (
        input  valid, input drawn,
        input  idx0, input idx1, input idx2, input idx3, input idx4, input idx5,
        input  triangles_so_far, input walk_done,
        output ready
    );
endinterface

@@ hdl/gmig_walk.sv @@
// Walk position counters: grid squares row by row, then the four skirts.
`timescale 1ns / 1ps

module gmig_walk #(
    parameter int CELL_SIZE = gmig_pkg::CELL_SIZE_DEF,
    parameter int POS_W     = $clog2(CELL_SIZE)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    output logic [POS_W-1:0]      col,
    output logic [POS_W-1:0]      row,
    output gmig_pkg::region_t     region,
    output logic                  last
);
    import gmig_pkg::*;

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(CELL_SIZE - 1);

    logic [POS_W-1:0] col_reg;
    logic [POS_W-1:0] col_next;
    logic [POS_W-1:0] row_reg;
    logic [POS_W-1:0] row_next;
    region_t          region_reg;
    region_t          region_next;
    logic             col_wrap;

    assign col_wrap = (col_reg == POS_LAST);

    // Work out the position of the following square
    always_comb
    begin
        col_next    = col_wrap ? '0 : col_reg + POS_W'(1);
        row_next    = row_reg;
        region_next = region_reg;
        case (region_reg)
            REGION_TOP, REGION_BOTTOM, REGION_LEFT:
            begin
                if (col_wrap)
                begin
                    region_next = region_reg + REGION_W'(1);
                end
            end
            REGION_RIGHT:
            begin
                // End of walk: return to the first grid square
                if (col_wrap)
                begin
                    row_next    = '0;
                    region_next = REGION_GRID;
                end
            end
            default:
            begin
                region_next = REGION_GRID;
                if (col_wrap)
                begin
                    if (row_reg == POS_LAST)
                    begin
                        row_next    = '0;
                        region_next = REGION_TOP;
                    end
                    else
                    begin
                        row_next = row_reg + POS_W'(1);
                    end
                end
            end
        endcase
    end

    // Advance once per accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            region_reg <= REGION_GRID;
        end
        else if (step)
        begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            region_reg <= region_next;
        end
    end

    assign col    = col_reg;
    assign row    = row_reg;
    assign region = region_reg;
    assign last   = (region_reg == REGION_RIGHT) && col_wrap;

endmodule

@@ hdl/gmig_index.sv @@
// Six vertex indices of one square from its region and position.
`timescale 1ns / 1ps

module gmig_index #(
    parameter int CELL_SIZE = gmig_pkg::CELL_SIZE_DEF,
    parameter int POS_W     = $clog2(CELL_SIZE)
) (
    input  logic [POS_W-1:0]  col,
    input  logic [POS_W-1:0]  row,
    input  gmig_pkg::region_t region,
    output gmig_pkg::idx_t    tri_idx [gmig_pkg::SQUARE_VERTS]
);
    import gmig_pkg::*;

    // Vertex layout, kept modulo the index width
    localparam int   VSTRIDE     = CELL_SIZE + 1;
    localparam idx_t VS          = IDX_W'(VSTRIDE);
    localparam idx_t SKIRT_TOP   = IDX_W'(VSTRIDE * VSTRIDE);
    localparam idx_t LAST_ROW    = IDX_W'(VSTRIDE * VSTRIDE - VSTRIDE);
    localparam idx_t SKIRT_BOT   = IDX_W'(VSTRIDE * VSTRIDE + VSTRIDE);
    localparam idx_t SKIRT_LEFT  = IDX_W'(VSTRIDE * VSTRIDE + 2 * VSTRIDE);
    localparam idx_t SKIRT_RIGHT = IDX_W'(VSTRIDE * VSTRIDE + 3 * VSTRIDE);
    localparam idx_t RIGHT_EDGE  = IDX_W'(VSTRIDE - 1);

    logic [POS_W-1:0] mul_op;
    idx_t             prod;
    idx_t             col_i;
    idx_t             base;
    idx_t             t0;
    idx_t             t1;
    idx_t             b0;
    idx_t             b1;

    // Grid squares scale the row, side skirts scale the position along them
    assign mul_op = (region == REGION_LEFT || region == REGION_RIGHT) ? col : row;
    assign prod   = IDX_W'(mul_op) * VS;
    assign col_i  = IDX_W'(col);
    assign base   = prod + col_i;

    // Pick edge vertices and winding per region
    always_comb
    begin
        t0 = '0;
        t1 = '0;
        b0 = '0;
        b1 = '0;
        tri_idx = '{default: '0};
        case (region)
            REGION_TOP:
            begin
                t0 = col_i;
                t1 = t0 + IDX_W'(1);
                b0 = SKIRT_TOP + col_i;
                b1 = b0 + IDX_W'(1);
                tri_idx = '{b0, t0, t1, b1, b0, t1};
            end
            REGION_BOTTOM:
            begin
                t0 = LAST_ROW + col_i;
                t1 = t0 + IDX_W'(1);
                b0 = SKIRT_BOT + col_i;
                b1 = b0 + IDX_W'(1);
                tri_idx = '{t1, t0, b0, t1, b0, b1};
            end
            REGION_LEFT:
            begin
                t0 = prod;
                t1 = t0 + VS;
                b0 = SKIRT_LEFT + col_i;
                b1 = b0 + IDX_W'(1);
                tri_idx = '{t1, t0, b0, t1, b0, b1};
            end
            REGION_RIGHT:
            begin
                t0 = RIGHT_EDGE + prod;
                t1 = t0 + VS;
                b0 = SKIRT_RIGHT + col_i;
                b1 = b0 + IDX_W'(1);
                tri_idx = '{b0, t0, t1, b1, b0, t1};
            end
            default:
            begin
                // Alternate the diagonal on row and column parity
                t0 = base;
                t1 = base + IDX_W'(1);
                b0 = base + VS;
                b1 = b0 + IDX_W'(1);
                if (col[0] == row[0])
                begin
                    tri_idx = '{t0, b0, b1, t0, b1, t1};
                end
                else
                begin
                    tri_idx = '{t1, t0, b0, t1, b0, b1};
                end
            end
        endcase
    end

endmodule

@@ hdl/grid_mesh_index_generator.sv @@
// Top level: triangle index generator for a terrain grid with four skirts.
`timescale 1ns / 1ps

// Takes one empty flag per square, in walk order: CELL_SIZE x CELL_SIZE grid
// squares row by row, then CELL_SIZE squares each of the top, bottom, left and
// right skirts. Each item gives one result with six vertex indices (two
// triangles), the running triangle count and a flag on the last square of the
// walk, after which positions and count start again. With skip_empty set, an
// empty square gives drawn = 0, all-zero indices and an unchanged count.
// Every item passes an input register and then a result register before its result
// is offered, and one item is taken every cycle while the output is not stalled;
// the output stage alone sets the pace, stalling only while results wait.
// Write skip_empty only while no item is in flight.

module grid_mesh_index_generator #(
    parameter int CELL_SIZE = gmig_pkg::CELL_SIZE_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    gmig_in_if.sink    in_ch,
    gmig_out_if.source out_ch
);
    import gmig_pkg::*;

    localparam int POS_W = $clog2(CELL_SIZE);

    logic             skip_empty_reg;

    // Walk position of the next item to arrive
    logic [POS_W-1:0] walk_col;
    logic [POS_W-1:0] walk_row;
    region_t          walk_region;
    logic             walk_last;

    // Input register
    logic             s1_valid_reg;
    logic             s1_empty_reg;
    logic [POS_W-1:0] s1_col_reg;
    logic [POS_W-1:0] s1_row_reg;
    region_t          s1_region_reg;
    logic             s1_last_reg;

    // Result register
    logic             out_valid_reg;
    logic             out_drawn_reg;
    idx_t             out_idx_reg [SQUARE_VERTS];
    tri_count_t       out_tris_reg;
    logic             out_done_reg;

    tri_count_t       total_reg;
    tri_count_t       total_next;
    tri_count_t       tri_sum;
    idx_t             sq_idx [SQUARE_VERTS];
    logic             drawn;
    logic             in_take;
    logic             out_free;
    logic             s1_move;

    // Handshake: the result register frees when empty or taken
    assign out_free = !out_valid_reg || out_ch.ready;
    assign s1_move  = s1_valid_reg && out_free;
    assign in_ch.ready = !s1_valid_reg || out_free;
    assign in_take  = in_ch.valid && in_ch.ready;

    // Hold the configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_empty_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            skip_empty_reg <= cfg_wr_data;
        end
    end

    gmig_walk #(
        .CELL_SIZE (CELL_SIZE),
        .POS_W     (POS_W)
    ) u_walk (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (in_take),
        .col    (walk_col),
        .row    (walk_row),
        .region (walk_region),
        .last   (walk_last)
    );

    // Capture the item with its walk position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            s1_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_empty_reg  <= in_ch.square_empty;
            s1_col_reg    <= walk_col;
            s1_row_reg    <= walk_row;
            s1_region_reg <= walk_region;
            s1_last_reg   <= walk_last;
        end
    end

    gmig_index #(
        .CELL_SIZE (CELL_SIZE),
        .POS_W     (POS_W)
    ) u_index (
        .col     (s1_col_reg),
        .row     (s1_row_reg),
        .region  (s1_region_reg),
        .tri_idx (sq_idx)
    );

    // Count triangles; restart after the last square
    assign drawn      = !(skip_empty_reg && s1_empty_reg);
    assign tri_sum    = total_reg + (drawn ? TRI_W'(TRIS_PER_SQUARE) : '0);
    assign total_next = s1_last_reg ? '0 : tri_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_move)
            begin
                total_reg <= total_next;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Load the result register; zero the indices of a dropped square
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_drawn_reg <= drawn;
            for (int k = 0; k < SQUARE_VERTS; k++)
            begin
                out_idx_reg[k] <= drawn ? sq_idx[k] : '0;
            end
            out_tris_reg <= tri_sum;
            out_done_reg <= s1_last_reg;
        end
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.drawn            = out_drawn_reg;
    assign out_ch.idx0             = out_idx_reg[0];
    assign out_ch.idx1             = out_idx_reg[1];
    assign out_ch.idx2             = out_idx_reg[2];
    assign out_ch.idx3             = out_idx_reg[3];
    assign out_ch.idx4             = out_idx_reg[4];
    assign out_ch.idx5             = out_idx_reg[5];
    assign out_ch.triangles_so_far = out_tris_reg;
    assign out_ch.walk_done        = out_done_reg;

endmodule

@@ tb/tb_grid_mesh_index_generator.sv @@
// Self-checking testbench for the grid mesh index generator: predicted indices, random flow control.
`timescale 1ns / 1ps

module tb_grid_mesh_index_generator;
    import gmig_pkg::*;

    localparam int GRID_N     = CELL_SIZE_DEF;
    localparam int NUM_PHASES = 8;
    // Random part: about 1600 squares spread over the phases
    localparam int PHASE_ITEMS = 1600 / NUM_PHASES;
    localparam int DRAIN_WAIT  = 4;
    localparam int LONG_HOLD   = 200;
    localparam int CYCLE_LIMIT = 500000;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic                         drawn;
        idx_t [SQUARE_VERTS-1:0]      idx;
        tri_count_t                   tris;
        logic                         walk_done;
    } square_result_t;

    // Tracks the walk position and holds the indices each accepted square should give
    class square_index_tracker #(int N = 64);
        bit             skip_empty;
        int             col;
        int             row;
        region_t        region;
        tri_count_t     tri_total;
        square_result_t expected_squares[$];
        int             errors;

        function new();
            skip_empty = 1'b0;
            errors     = 0;
            restart_walk();
        endfunction

        function void restart_walk();
            col       = 0;
            row       = 0;
            region    = REGION_GRID;
            tri_total = '0;
        endfunction

        function void set_skip(bit value);
            skip_empty = value;
        endfunction

        function int pending();
            return expected_squares.size();
        endfunction

        // Work out the six indices of the current square, then advance the walk
        function void note_square(bit empty);
            int             vs;
            int             top;
            int             t0;
            int             t1;
            int             b0;
            int             b1;
            int             base;
            int             v[SQUARE_VERTS];
            bit             draw;
            bit             done;
            square_result_t res;

            vs   = N + 1;
            top  = vs * vs;
            draw = !(skip_empty && empty);
            done = 1'b0;

            case (region)
                REGION_TOP:
                begin
                    t0 = col;
                    t1 = t0 + 1;
                    b0 = top + col;
                    b1 = b0 + 1;
                    v = '{b0, t0, t1, b1, b0, t1};
                end
                REGION_BOTTOM:
                begin
                    t0 = top - vs + col;
                    t1 = t0 + 1;
                    b0 = top + vs + col;
                    b1 = b0 + 1;
                    v = '{t1, t0, b0, t1, b0, b1};
                end
                REGION_LEFT:
                begin
                    t0 = col * vs;
                    t1 = t0 + vs;
                    b0 = top + 2 * vs + col;
                    b1 = b0 + 1;
                    v = '{t1, t0, b0, t1, b0, b1};
                end
                REGION_RIGHT:
                begin
                    t0 = vs - 1 + col * vs;
                    t1 = t0 + vs;
                    b0 = top + 3 * vs + col;
                    b1 = b0 + 1;
                    v = '{b0, t0, t1, b1, b0, t1};
                end
                default:
                begin
                    // Diagonal flips with row and column parity
                    base = row * vs + col;
                    if ((col & 1) == (row & 1))
                        v = '{base, base + vs, base + vs + 1, base, base + vs + 1, base + 1};
                    else
                        v = '{base + 1, base, base + vs, base + 1, base + vs, base + vs + 1};
                end
            endcase

            if (draw)
                tri_total = tri_total + tri_count_t'(TRIS_PER_SQUARE);

            res.drawn = draw;
            for (int k = 0; k < SQUARE_VERTS; k++)
                res.idx[k] = draw ? idx_t'(v[k]) : '0;
            res.tris = tri_total;

            // Advance along a skirt, or across the grid
            if (region >= REGION_TOP && region <= REGION_RIGHT)
            begin
                if (col + 1 >= N)
                begin
                    col = 0;
                    if (region == REGION_RIGHT)
                        done = 1'b1;
                    else
                        region = region_t'(region + 1);
                end
                else
                    col++;
            end
            else
            begin
                region = REGION_GRID;
                if (col + 1 >= N)
                begin
                    col = 0;
                    if (row + 1 >= N)
                    begin
                        row    = 0;
                        region = REGION_TOP;
                    end
                    else
                        row++;
                end
                else
                    col++;
            end

            res.walk_done = done;
            if (done)
                restart_walk();
            expected_squares.insert(expected_squares.size(), res);
        endfunction

        // Compare one result with the oldest expected square
        function void check_square(square_result_t got);
            square_result_t exp;

            if (expected_squares.size() == 0)
            begin
                $display("%0t: result with nothing expected, got %h", $time, got);
                errors++;
                return;
            end
            exp = expected_squares.pop_front();
            if (got.drawn !== exp.drawn)
            begin
                $display("%0t: drawn expected %0d got %0d", $time, exp.drawn, got.drawn);
                errors++;
            end
            for (int k = 0; k < SQUARE_VERTS; k++)
                if (got.idx[k] !== exp.idx[k])
                begin
                    $display("%0t: idx%0d expected %0d got %0d",
                             $time, k, exp.idx[k], got.idx[k]);
                    errors++;
                end
            if (got.tris !== exp.tris)
            begin
                $display("%0t: triangles_so_far expected %0d got %0d",
                         $time, exp.tris, got.tris);
                errors++;
            end
            if (got.walk_done !== exp.walk_done)
            begin
                $display("%0t: walk_done expected %0d got %0d",
                         $time, exp.walk_done, got.walk_done);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    gmig_in_if  in_ch();
    gmig_out_if out_ch();

    square_index_tracker #(GRID_N) squares;

    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_ask;
    int  cycle_count;

    grid_mesh_index_generator #(
        .CELL_SIZE (GRID_N)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    // Free-running clock
    initial
        clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Give up on a hung run
    initial
        cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Drive ready: random stalls, plus a long hold-off on request
    initial
    begin : result_ready_driver
        bit hold_seen;
        int hold_left;

        hold_seen    = 1'b0;
        hold_left    = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n !== 1'b1)
                out_ch.ready <= 1'b0;
            else if (hold_ask != hold_seen)
            begin
                hold_seen = hold_ask;
                hold_left = LONG_HOLD;
                out_ch.ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Check each result on the falling clock edge before it is taken
    always @(negedge clk)
    begin : result_monitor
        square_result_t got;

        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            got.drawn     = out_ch.drawn;
            got.idx[0]    = out_ch.idx0;
            got.idx[1]    = out_ch.idx1;
            got.idx[2]    = out_ch.idx2;
            got.idx[3]    = out_ch.idx3;
            got.idx[4]    = out_ch.idx4;
            got.idx[5]    = out_ch.idx5;
            got.tris      = out_ch.triangles_so_far;
            got.walk_done = out_ch.walk_done;
            squares.check_square(got);
        end
    end

    task automatic set_idling(idle_mode_t mode);
        case (mode)
            IDLE_SEND:
            begin
                send_idle_pct  = 66;
                recv_stall_pct <= 0;
            end
            IDLE_RECV:
            begin
                send_idle_pct  = 0;
                recv_stall_pct <= 66;
            end
            IDLE_BOTH:
            begin
                send_idle_pct  = 14;
                recv_stall_pct <= 14;
            end
            default:
            begin
                send_idle_pct  = 0;
                recv_stall_pct <= 0;
            end
        endcase
    endtask

    // Offer one square flag and hold it until taken
    task automatic send_square(bit empty);
        bit taken;

        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.square_empty <= empty;
        do
        begin
            @(negedge clk);
            taken = (in_ch.ready === 1'b1);
            @(posedge clk);
        end
        while (!taken);
        squares.note_square(empty);
    endtask

    // Stop offering and wait until every expected result is in
    task automatic drain_squares();
        in_ch.valid <= 1'b0;
        while (squares.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_skip(bit value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        squares.set_skip(value);
    endtask

    initial
    begin : stimulus
        int  empty_pct;
        bit  skip;

        squares            = new();
        rst_n              <= 1'b0;
        cfg_wr_en          <= 1'b0;
        cfg_wr_data        <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.square_empty <= 1'b0;
        hold_ask           <= 1'b0;
        send_idle_pct      = 0;
        recv_stall_pct     <= 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full pattern: empty flags ignored, both diagonals
        set_idling(IDLE_NONE);
        write_skip(1'b0);
        send_square(1'b0);
        send_square(1'b1);
        send_square(1'b0);
        send_square(1'b1);
        drain_squares();

        // Dropped squares between drawn ones: count holds across drops
        write_skip(1'b1);
        send_square(1'b1);
        send_square(1'b0);
        send_square(1'b1);
        send_square(1'b1);
        send_square(1'b0);
        send_square(1'b0);
        send_square(1'b1);
        send_square(1'b0);
        drain_squares();

        // Random phases through every idling mode and both settings
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            skip = ((ph + ph / 4) % 2) != 0;
            write_skip(skip);
            set_idling(idle_mode_t'(ph % 4));
            empty_pct = 25 * $urandom_range(4);
            if (ph % 4 == 0)
                hold_ask <= ~hold_ask;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_square($urandom_range(99) < empty_pct);
            drain_squares();
        end

        set_idling(IDLE_NONE);
        drain_squares();
        if (squares.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/gmig_pkg.sv
hdl/gmig_if.sv
hdl/gmig_walk.sv
hdl/gmig_index.sv
hdl/grid_mesh_index_generator.sv
tb/tb_grid_mesh_index_generator.sv
